// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/spsw_pkg.sv =====
// Shared types and constants of the servo pulse sequencer
`default_nettype none
package spsw_pkg;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_COMPARE = 2'd1,
        REQ_COMMAND = 2'd2
    } t_req_type;

    localparam int PIN_COUNT = 4;
    localparam logic [7:0] EVEN_COMPARE_RESET = 8'(6 + 125 + 125 / 2);
    localparam logic [7:0] LED_OFF_COUNT = 8'd128;
    localparam logic [7:0] DIGITAL_HIGH = 8'd255;
    localparam logic [2:0] INPUT_MASK = 3'h7;

    typedef struct packed {
        logic       tick;
        logic       match;
        logic [3:0] slot;
    } t_seq_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/spsw_seq.sv =====
// Slot sequencer: servo pin levels and compare value for one slot event
`default_nettype none
module spsw_seq #(
    parameter int SERVO_COUNT = 4
) (
    input  spsw_pkg::t_seq_ctl i_ctl,
    input  logic [7:0]         i_servo [SERVO_COUNT],
    input  logic [3:0]         i_pins,
    input  logic [7:0]         i_compare,
    input  logic [7:0]         i_even_cmp,
    output logic [3:0]         o_pins,
    output logic [7:0]         o_compare
);

    logic       w_live;
    logic [7:0] w_val;
    logic       w_level;

    always_comb begin
        w_live  = 1'b0;
        w_val   = 8'd0;
        o_pins  = i_pins;
        for (int i = 0; i < SERVO_COUNT; i++) begin
            if (i_ctl.slot[3:1] == 3'(i)) begin
                w_live = (i_servo[i] != 8'd0);
                w_val  = i_servo[i];
            end
            if (i == 3 && i_ctl.tick) begin
                if (i_servo[i] == 8'd0) begin
                    o_pins[3] = 1'b0;
                end else if (i_servo[i] == spsw_pkg::DIGITAL_HIGH) begin
                    o_pins[3] = 1'b1;
                end
            end
        end
        w_level = i_ctl.tick ? i_ctl.slot[0] : !i_ctl.slot[0];
        if (w_live && (i_ctl.tick || i_ctl.match)) begin
            for (int p = 0; p < spsw_pkg::PIN_COUNT; p++) begin
                if (i_ctl.slot[3:1] == 3'(p)) begin
                    o_pins[p] = w_level;
                end
            end
        end
        o_compare = i_compare;
        if (w_live && i_ctl.tick) begin
            o_compare = i_ctl.slot[0] ? w_val : i_even_cmp;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/servo_pulse_sequencer_watchdog.sv =====
// Top level: timed command buffer, watchdog, tick counter and servo slot sequencer
//
//   channel | direction | handshake                   | payload
//   input   | in        | i_in_valid / o_in_ready     | i_req_type .. i_new_outputs
//   result  | out       | o_out_valid / i_out_ready   | o_led_level .. o_snapshot_inputs
//   config  | in        | i_cfg_we                    | i_cfg_data
//
// One item per cycle while results are taken; its result is registered and shows in the cycle after the transfer.
// All state but the even compare updates in the cycle of the input transfer; the even compare updates on i_cfg_we.
// A stalled result holds; a new item is taken in the cycle the old result leaves.
// Synchronous active-low reset clears all control state; even compare resets to 193.
`default_nettype none
`include "assert_macros.svh"
module servo_pulse_sequencer_watchdog #(
    parameter int SERVO_COUNT = 4,
    parameter int SLOT_COUNT  = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [2:0] i_raw_pins,
    input  logic [7:0] i_new_servo_0,
    input  logic [7:0] i_new_servo_1,
    input  logic [7:0] i_new_servo_2,
    input  logic [7:0] i_new_servo_3,
    input  logic [7:0] i_new_watchdog,
    input  logic [7:0] i_new_execute_at,
    input  logic [2:0] i_new_outputs,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_led_level,
    output logic [3:0] o_servo_pins,
    output logic [2:0] o_output_pins,
    output logic [7:0] o_compare_value,
    output logic [7:0] o_tick_value,
    output logic [2:0] o_input_state,
    output logic       o_command_pending,
    output logic       o_applied,
    output logic [2:0] o_snapshot_inputs
);

    logic [7:0] r_even_cmp;
    logic [7:0] r_tick,    n_tick;
    logic [3:0] r_slot,    n_slot;
    logic [7:0] r_servo    [SERVO_COUNT];
    logic [7:0] n_servo    [SERVO_COUNT];
    logic [7:0] r_wd,      n_wd;
    logic [2:0] r_outs,    n_outs;
    logic [7:0] r_pend_servo [SERVO_COUNT];
    logic [7:0] r_pend_wd;
    logic [7:0] r_pend_time;
    logic [2:0] r_pend_outs;
    logic       r_pend_flag, n_pend_flag;
    logic       r_led,     n_led;
    logic [3:0] r_pins;
    logic [7:0] r_compare;
    logic [2:0] r_inputs,  n_inputs;
    logic       n_applied;
    logic [2:0] n_snap;
    logic       r_out_valid;

    logic       w_accept;
    logic       w_load_cmd;
    logic [7:0] w_cmd_servo [SERVO_COUNT];
    logic [7:0] w_diff;
    logic       w_apply;
    logic [7:0] w_wd_a;
    logic [3:0] w_slot_inc;
    logic [7:0] w_seq_servo [SERVO_COUNT];
    spsw_pkg::t_seq_ctl w_ctl;
    logic [3:0] w_pins_n;
    logic [7:0] w_compare_n;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        for (int i = 0; i < SERVO_COUNT; i++) begin
            case (i)
                0:       w_cmd_servo[i] = i_new_servo_0;
                1:       w_cmd_servo[i] = i_new_servo_1;
                2:       w_cmd_servo[i] = i_new_servo_2;
                3:       w_cmd_servo[i] = i_new_servo_3;
                default: w_cmd_servo[i] = 8'd0;
            endcase
        end
    end

    always_comb begin
        n_tick      = r_tick;
        n_slot      = r_slot;
        n_servo     = r_servo;
        n_wd        = r_wd;
        n_outs      = r_outs;
        n_pend_flag = r_pend_flag;
        n_led       = r_led;
        n_inputs    = r_inputs;
        n_applied   = 1'b0;
        n_snap      = 3'd0;
        w_load_cmd  = 1'b0;
        w_ctl       = '0;
        w_diff      = 8'd0;
        w_apply     = 1'b0;
        w_wd_a      = r_wd;
        w_slot_inc  = r_slot + 4'd1;
        w_seq_servo = r_servo;
        case (spsw_pkg::t_req_type'(i_req_type))
            spsw_pkg::REQ_TICK: begin
                n_tick = r_tick + 8'd1;
                if (n_tick == 8'd0) begin
                    n_led = 1'b1;
                end else if (n_tick == spsw_pkg::LED_OFF_COUNT) begin
                    n_led = 1'b0;
                end
                w_diff  = r_pend_time - n_tick;
                w_apply = r_pend_flag && (w_diff == 8'd0 || w_diff[7]);
                if (w_apply) begin
                    n_servo     = r_pend_servo;
                    w_wd_a      = r_pend_wd;
                    n_outs      = r_pend_outs;
                    n_pend_flag = 1'b0;
                    n_applied   = 1'b1;
                    n_snap      = r_inputs;
                end
                if (w_wd_a == 8'd0) begin
                    for (int i = 0; i < SERVO_COUNT; i++) begin
                        n_servo[i] = 8'd0;
                    end
                    n_wd = 8'd0;
                end else begin
                    n_wd = w_wd_a - 8'd1;
                end
                n_slot = (w_slot_inc >= 4'(SLOT_COUNT)) ? 4'd0 : w_slot_inc;
                w_ctl.tick  = 1'b1;
                w_ctl.slot  = n_slot;
                w_seq_servo = n_servo;
                n_inputs    = ~i_raw_pins & spsw_pkg::INPUT_MASK;
            end
            spsw_pkg::REQ_COMPARE: begin
                w_ctl.match = 1'b1;
                w_ctl.slot  = r_slot;
            end
            spsw_pkg::REQ_COMMAND: begin
                w_load_cmd  = 1'b1;
                n_pend_flag = 1'b1;
            end
            default: begin
            end
        endcase
    end

    spsw_seq #(
        .SERVO_COUNT(SERVO_COUNT)
    ) u_seq (
        .i_ctl      (w_ctl),
        .i_servo    (w_seq_servo),
        .i_pins     (r_pins),
        .i_compare  (r_compare),
        .i_even_cmp (r_even_cmp),
        .o_pins     (w_pins_n),
        .o_compare  (w_compare_n)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_cmp <= spsw_pkg::EVEN_COMPARE_RESET;
        end else if (i_cfg_we) begin
            r_even_cmp <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= 8'd0;
            r_slot      <= 4'd0;
            r_wd        <= 8'd0;
            r_outs      <= 3'd0;
            r_pend_flag <= 1'b0;
            r_led       <= 1'b0;
            r_pins      <= 4'd0;
            r_compare   <= 8'd0;
            r_inputs    <= 3'd0;
            for (int i = 0; i < SERVO_COUNT; i++) begin
                r_servo[i] <= 8'd0;
            end
        end else if (w_accept) begin
            r_tick      <= n_tick;
            r_slot      <= n_slot;
            r_wd        <= n_wd;
            r_outs      <= n_outs;
            r_pend_flag <= n_pend_flag;
            r_led       <= n_led;
            r_pins      <= w_pins_n;
            r_compare   <= w_compare_n;
            r_inputs    <= n_inputs;
            r_servo     <= n_servo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_load_cmd) begin
            r_pend_servo <= w_cmd_servo;
            r_pend_wd    <= i_new_watchdog;
            r_pend_time  <= i_new_execute_at;
            r_pend_outs  <= i_new_outputs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_led_level       <= n_led;
            o_servo_pins      <= w_pins_n;
            o_output_pins     <= n_outs;
            o_compare_value   <= w_compare_n;
            o_tick_value      <= n_tick;
            o_input_state     <= n_inputs;
            o_command_pending <= n_pend_flag;
            o_applied         <= n_applied;
            o_snapshot_inputs <= n_snap;
        end
    end

    `ASSERT_IMPL(a_applied_clears_pending, i_clk, i_rst_n, o_out_valid && o_applied, !o_command_pending)
    `ASSERT_IMPL(a_snap_zero_unless_applied, i_clk, i_rst_n, o_out_valid && !o_applied, o_snapshot_inputs == 3'd0)
    `ASSERT_NEXT(a_command_sets_pending, i_clk, i_rst_n, w_accept && w_load_cmd, r_pend_flag && o_command_pending)
    `ASSERT_NEXT(a_transfer_gives_result, i_clk, i_rst_n, w_accept, o_out_valid && o_tick_value == r_tick)

endmodule
`default_nettype wire
